// File: hdl/fcw_pkg.sv
`default_nettype none

package fcw_pkg;

  // Item actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_NEXT  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ACCEPTED    = 3'd0;
  localparam logic [2:0] ST_SECTOR      = 3'd1;
  localparam logic [2:0] ST_FINISHED    = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd3;
  localparam logic [2:0] ST_BAD_CLUSTER = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_RESERVED     = 3'd0;
  localparam logic [2:0] REG_COPIES       = 3'd1;
  localparam logic [2:0] REG_TABLE_SECT   = 3'd2;
  localparam logic [2:0] REG_ROOT_ENTRIES = 3'd3;
  localparam logic [2:0] REG_CLUSTER_SECT = 3'd4;

  localparam logic [15:0] CHAIN_END          = 16'hFFFF;
  localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;
  localparam int          DIR_ENTRY_SHIFT    = 5;   // 32 bytes per root entry

  typedef struct packed {
    logic [15:0] reserved_sector_count;
    logic [7:0]  table_copies;
    logic [15:0] sectors_per_table;
    logic [15:0] root_entry_count;
    logic [7:0]  cluster_sectors;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] entry_index;
    logic [15:0] entry_value;
    logic [15:0] start_cluster;
    logic [31:0] file_bytes;
    logic [31:0] size_limit;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sector_address;
    logic [31:0] buffer_offset;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [23:0] fat_sectors;
    logic [15:0] dir_sectors;
    logic [23:0] cluster_base;
  } addr_terms_t;

endpackage

`default_nettype wire

// File: hdl/fcw_table_ram.sv
`default_nettype none

module fcw_table_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [15:0]       wdata,
  output logic      [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/fcw_addr_unit.sv
`default_nettype none

module fcw_addr_unit
  import fcw_pkg::*;
#(
  parameter int SECTOR_BYTES = 512
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire cfg_t        cfg,
  input  wire logic [15:0] cur_cluster,
  input  wire logic [7:0]  per,
  output addr_terms_t      terms
);

  // Root directory sectors = floor(root*32 / SECTOR_BYTES), by a ceiling
  // reciprocal; exact for a 21-bit dividend with this shift.
  localparam int ROOT_SHIFT = 36;
  localparam int DIVD_W     = 16 + DIR_ENTRY_SHIFT;
  localparam int RECIP_W    = 38 - $clog2(SECTOR_BYTES);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << ROOT_SHIFT) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES));

  logic [23:0]                fat_prod;
  logic [DIVD_W+RECIP_W-1:0]  root_prod;
  logic [23:0]                clus_prod;
  logic [DIVD_W-1:0]          root_bytes;
  logic [15:0]                clus_rel;

  assign root_bytes = {cfg.root_entry_count, DIR_ENTRY_SHIFT'(0)};
  assign clus_rel   = cur_cluster - FIRST_DATA_CLUSTER;

  always_ff @(posedge clk) begin
    if (en) begin
      fat_prod  <= 24'(cfg.table_copies * cfg.sectors_per_table);
      root_prod <= (DIVD_W+RECIP_W)'(root_bytes * RECIP);
      clus_prod <= 24'(clus_rel * per);
    end
  end

  assign terms.fat_sectors  = fat_prod;
  assign terms.dir_sectors  = 16'(root_prod >> ROOT_SHIFT);
  assign terms.cluster_base = clus_prod;

endmodule

`default_nettype wire

// File: hdl/fat16_cluster_chain_sector_walker_core.sv
`default_nettype none

// FAT16 cluster-chain sector walker.
// Input channel (in_valid/in_stall/in_data) takes one word per item: load a
// table entry, start a transfer, or ask for the next sector. Every item gives
// exactly one result word on the output channel (out_valid/out_stall/out_data).
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while no item is in flight; the core does not enforce this.
// The result word is registered when the walker leaves CALC, once the output
// register is free to take it.
// One item is in work at a time: in_stall is high in CALC. The accept edge
// issues the single allocation table read and the address products; the edge
// that leaves CALC registers the result formed from the table data and updates
// the walker state. A result that waits on out_stall does not block the next
// item from being taken; that item then holds in CALC until the output register
// frees up, keeping in_stall high.
// Reset clears the walker (no active transfer) and loads the configuration
// defaults. The table itself holds no reset value: entries read before they
// are loaded are undefined.

module fat16_cluster_chain_sector_walker_core
  import fcw_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int SECTOR_BYTES  = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int          IDX_W     = $clog2(TABLE_ENTRIES);
  localparam logic [16:0] TABLE_LIM = 17'(TABLE_ENTRIES);
  localparam logic [31:0] SB32      = 32'(SECTOR_BYTES);
  localparam logic [31:0] SAT_EDGE  = 32'hFFFF_FFFF - SB32;

  typedef enum logic {IDLE, CALC} state_t;

  state_t      state;
  cfg_t        cfg;
  in_word_t    item;
  logic [15:0] cur_cluster;
  logic [7:0]  sector_in_cluster;
  logic [31:0] bytes_done;
  logic [31:0] target_size;
  logic        transfer_active;

  logic [15:0] cur_cluster_next;
  logic [7:0]  sector_in_cluster_next;
  logic [31:0] bytes_done_next;
  logic [31:0] target_size_next;
  logic        transfer_active_next;
  out_word_t   result;

  logic              in_go;
  logic              out_free;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [15:0]       ram_rdata;
  logic [7:0]        per;
  addr_terms_t       terms;

  assign in_stall = (state == CALC);
  assign in_go    = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign per      = (cfg.cluster_sectors == 8'd0) ? 8'd1 : cfg.cluster_sectors;

  // Loads with an in-range index write at the accept edge; every other item reads the current cluster.
  assign ram_we   = in_go && (in_data.action == ACT_LOAD)
                    && ({1'b0, in_data.entry_index} < TABLE_LIM);
  assign ram_addr = (in_data.action == ACT_LOAD) ? in_data.entry_index[IDX_W-1:0]
                                                 : cur_cluster[IDX_W-1:0];

  fcw_table_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .en    (in_go),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.entry_value),
    .rdata (ram_rdata)
  );

  fcw_addr_unit #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_addr (
    .clk         (clk),
    .en          (in_go),
    .cfg         (cfg),
    .cur_cluster (cur_cluster),
    .per         (per),
    .terms       (terms)
  );

  always_comb begin
    logic [8:0]  count;
    logic [31:0] bytes_sum;
    logic        size_done;
    logic        advance;

    cur_cluster_next       = cur_cluster;
    sector_in_cluster_next = sector_in_cluster;
    bytes_done_next        = bytes_done;
    target_size_next       = target_size;
    transfer_active_next   = transfer_active;
    result                 = '0;
    result.status          = ST_ACCEPTED;

    count     = {1'b0, sector_in_cluster} + 9'd1;
    bytes_sum = (bytes_done > SAT_EDGE) ? 32'hFFFF_FFFF : bytes_done + SB32;
    size_done = (bytes_sum >= target_size);
    advance   = (count >= {1'b0, per}) || size_done;

    case (item.action)
      ACT_START: begin
        if (item.file_bytes > item.size_limit) begin
          transfer_active_next = 1'b0;
          result.status        = ST_TOO_LARGE;
        end else begin
          cur_cluster_next       = item.start_cluster;
          sector_in_cluster_next = 8'd0;
          bytes_done_next        = 32'd0;
          target_size_next       = item.file_bytes;
          transfer_active_next   = 1'b1;
        end
      end
      ACT_NEXT: begin
        if (!transfer_active || cur_cluster == CHAIN_END || bytes_done >= target_size) begin
          transfer_active_next = 1'b0;
          result.status        = ST_FINISHED;
        end else if (cur_cluster < FIRST_DATA_CLUSTER
                     || {1'b0, cur_cluster} >= TABLE_LIM) begin
          transfer_active_next = 1'b0;
          result.status        = ST_BAD_CLUSTER;
        end else begin
          result.status         = ST_SECTOR;
          result.sector_address = 32'(cfg.reserved_sector_count)
                                + 32'(terms.fat_sectors)
                                + 32'(terms.dir_sectors)
                                + 32'(terms.cluster_base)
                                + 32'(sector_in_cluster);
          result.buffer_offset  = bytes_done;
          bytes_done_next       = bytes_sum;
          if (advance) begin
            // follow the chain
            cur_cluster_next       = ram_rdata;
            sector_in_cluster_next = 8'd0;
          end else begin
            sector_in_cluster_next = count[7:0];
          end
          if (size_done || (advance && ram_rdata == CHAIN_END)) begin
            result.last          = 1'b1;
            transfer_active_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= IDLE;
      out_valid         <= 1'b0;
      cur_cluster       <= '0;
      sector_in_cluster <= '0;
      bytes_done        <= '0;
      target_size       <= '0;
      transfer_active   <= 1'b0;
    end else begin
      // drop a taken word unless a new one replaces it below
      if (out_valid && !out_stall && state != CALC) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_go) begin
            item  <= in_data;
            state <= CALC;
          end
        end
        CALC: begin
          // hold until the output register can take the word
          if (out_free) begin
            out_valid         <= 1'b1;
            out_data          <= result;
            cur_cluster       <= cur_cluster_next;
            sector_in_cluster <= sector_in_cluster_next;
            bytes_done        <= bytes_done_next;
            target_size       <= target_size_next;
            transfer_active   <= transfer_active_next;
            state             <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reserved_sector_count <= 16'd1;
      cfg.table_copies          <= 8'd2;
      cfg.sectors_per_table     <= 16'd32;
      cfg.root_entry_count      <= 16'd512;
      cfg.cluster_sectors       <= 8'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RESERVED:     cfg.reserved_sector_count <= cfg_data;
        REG_COPIES:       cfg.table_copies          <= cfg_data[7:0];
        REG_TABLE_SECT:   cfg.sectors_per_table     <= cfg_data;
        REG_ROOT_ENTRIES: cfg.root_entry_count      <= cfg_data;
        REG_CLUSTER_SECT: cfg.cluster_sectors       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: bench/fcw_walk_monitor.sv
`timescale 1ns / 1ps

module fcw_walk_monitor
  import fcw_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int SECTOR_BYTES  = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          words_owed,
  output int          mismatch_count
);

  localparam cfg_t GEOM_AT_RESET = {16'd1, 8'd2, 16'd32, 16'd512, 8'd4};

  logic [15:0] chain_map [TABLE_ENTRIES];
  logic [15:0] cur_cluster;
  logic [7:0]  cur_sector;
  logic [31:0] bytes_given;
  logic [31:0] bytes_wanted;
  logic        walking;
  cfg_t        geom;
  out_word_t   expected_words [$];

  // Advance the walker by one input word and return the result word it owes.
  function automatic out_word_t walk_step(input in_word_t w);
    out_word_t   res;
    logic [31:0] per;
    logic [31:0] first_sector;
    logic [31:0] next_count;
    res = '0;
    case (w.action)
      ACT_LOAD: begin
        if (int'(w.entry_index) < TABLE_ENTRIES) chain_map[w.entry_index] = w.entry_value;
        res.status = ST_ACCEPTED;
      end
      ACT_START: begin
        if (w.file_bytes > w.size_limit) begin
          walking    = 1'b0;
          res.status = ST_TOO_LARGE;
        end else begin
          cur_cluster  = w.start_cluster;
          cur_sector   = '0;
          bytes_given  = '0;
          bytes_wanted = w.file_bytes;
          walking      = 1'b1;
          res.status   = ST_ACCEPTED;
        end
      end
      ACT_NEXT: begin
        if (!walking || cur_cluster == CHAIN_END || bytes_given >= bytes_wanted) begin
          walking    = 1'b0;
          res.status = ST_FINISHED;
        end else if (cur_cluster < FIRST_DATA_CLUSTER || int'(cur_cluster) >= TABLE_ENTRIES) begin
          walking    = 1'b0;
          res.status = ST_BAD_CLUSTER;
        end else begin
          per = (geom.cluster_sectors == '0) ? 32'd1 : 32'(geom.cluster_sectors);
          first_sector = 32'(geom.reserved_sector_count)
                       + 32'(geom.table_copies) * 32'(geom.sectors_per_table)
                       + ((32'(geom.root_entry_count) << DIR_ENTRY_SHIFT) / 32'(SECTOR_BYTES));
          res.status         = ST_SECTOR;
          res.sector_address = first_sector
                             + (32'(cur_cluster) - 32'(FIRST_DATA_CLUSTER)) * per
                             + 32'(cur_sector);
          res.buffer_offset  = bytes_given;
          next_count = 32'(cur_sector) + 32'd1;
          // saturate the byte count
          if (bytes_given > 32'hFFFF_FFFF - 32'(SECTOR_BYTES)) bytes_given = '1;
          else bytes_given = bytes_given + 32'(SECTOR_BYTES);
          if (next_count >= per || bytes_given >= bytes_wanted) begin
            cur_cluster = chain_map[cur_cluster];
            cur_sector  = '0;
          end else begin
            cur_sector = next_count[7:0];
          end
          if (bytes_given >= bytes_wanted || cur_cluster == CHAIN_END) begin
            res.last = 1'b1;
            walking  = 1'b0;
          end
        end
      end
      default: res.status = ST_ACCEPTED;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      foreach (chain_map[i]) chain_map[i] = '0;
      cur_cluster    = '0;
      cur_sector     = '0;
      bytes_given    = '0;
      bytes_wanted   = '0;
      walking        = 1'b0;
      geom           = GEOM_AT_RESET;
      mismatch_count = 0;
      expected_words.delete();
      words_owed <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0d", out_data.status);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("sector_address", want.sector_address, out_data.sector_address);
          check_field("buffer_offset", want.buffer_offset, out_data.buffer_offset);
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_RESERVED:     geom.reserved_sector_count = cfg_data;
          REG_COPIES:       geom.table_copies          = cfg_data[7:0];
          REG_TABLE_SECT:   geom.sectors_per_table     = cfg_data;
          REG_ROOT_ENTRIES: geom.root_entry_count      = cfg_data;
          REG_CLUSTER_SECT: geom.cluster_sectors       = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_words.push_back(walk_step(in_data));
      words_owed <= expected_words.size();
    end
  end

endmodule

// File: bench/tb_fat16_cluster_chain_sector_walker_core.sv
`timescale 1ns / 1ps

module tb_fat16_cluster_chain_sector_walker_core;
  import fcw_pkg::*;

  localparam int TABLE_ENTRIES   = 4096;
  localparam int SECTOR_BYTES    = 512;
  localparam int IDLE_LIMIT      = 2000;
  localparam int WORDS_PER_PHASE = 300;
  localparam int PHASES          = 5;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  int          words_owed;
  int          mismatch_count;

  bit          loaded [TABLE_ENTRIES];
  logic [15:0] loaded_list [$];
  int          burst_left  = 0;
  int          words_sent  = 0;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  fat16_cluster_chain_sector_walker_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fcw_walk_monitor #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) walk_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .words_owed    (words_owed),
    .mismatch_count(mismatch_count)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stretches of no stall, random stall and a fixed pattern, plus long hold-offs.
  initial begin : receiver
    int segment;
    int span;
    int mode;
    int tick;
    segment = 0;
    tick    = 0;
    @(negedge rst);
    forever begin
      segment++;
      if (segment == 12 || $urandom_range(0, 60) == 0) begin
        // hold off long enough for the walker to back up into its input
        repeat ($urandom_range(150, 300)) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 60);
        repeat (span) begin
          @(posedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: begin
              tick++;
              out_stall <= (tick % 3 != 0);
            end
          endcase
        end
      end
    end
  end

  function automatic in_word_t scrambled(input logic [1:0] act);
    logic [127:0] raw;
    in_word_t     w;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    w = raw[$bits(in_word_t)-1:0];
    w.action = act;
    return w;
  endfunction

  task automatic put_word(input in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (w.action != ACT_NONE &&
        !(w.action == ACT_LOAD && int'(w.entry_index) >= TABLE_ENTRIES)) words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_geometry(input cfg_t g);
    cfg_write <= 1'b1;
    cfg_index <= REG_RESERVED;
    cfg_data  <= g.reserved_sector_count;
    @(posedge clk);
    cfg_index <= REG_COPIES;
    cfg_data  <= 16'(g.table_copies);
    @(posedge clk);
    cfg_index <= REG_TABLE_SECT;
    cfg_data  <= g.sectors_per_table;
    @(posedge clk);
    cfg_index <= REG_ROOT_ENTRIES;
    cfg_data  <= g.root_entry_count;
    @(posedge clk);
    cfg_index <= REG_CLUSTER_SECT;
    cfg_data  <= 16'(g.cluster_sectors);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Track which table slots hold a value so no walk ever reads an unloaded one.
  task automatic load_entry(input logic [15:0] idx, input logic [15:0] val);
    in_word_t w;
    w = scrambled(ACT_LOAD);
    w.entry_index = idx;
    w.entry_value = val;
    if (int'(idx) < TABLE_ENTRIES && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    put_word(w);
  endtask

  task automatic start_file(input logic [15:0] first, input logic [31:0] size,
                            input logic [31:0] limit);
    in_word_t w;
    w = scrambled(ACT_START);
    w.start_cluster = first;
    w.file_bytes    = size;
    w.size_limit    = limit;
    put_word(w);
  endtask

  task automatic next_sector();
    put_word(scrambled(ACT_NEXT));
  endtask

  // Links only ever point at loaded slots or at values the walker never looks up.
  function automatic logic [15:0] safe_link();
    case ($urandom_range(0, 9))
      0, 1: return CHAIN_END;
      2: return 16'($urandom_range(0, 1));
      3: return 16'($urandom_range(TABLE_ENTRIES, 16'hFFFE));
      default: return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endcase
  endfunction

  task automatic random_load();
    logic [15:0] idx;
    case ($urandom_range(0, 9))
      0: idx = 16'($urandom_range(0, 1));
      1: idx = 16'($urandom_range(TABLE_ENTRIES, 16'hFFFF));
      2: idx = 16'($urandom_range(2, TABLE_ENTRIES - 1));
      default: idx = 16'($urandom_range(2, 63));
    endcase
    if (int'(idx) >= TABLE_ENTRIES) load_entry(idx, 16'($urandom()));
    else if ($urandom_range(0, 7) == 0) load_entry(idx, idx);
    else load_entry(idx, safe_link());
  endtask

  task automatic random_transfer();
    logic [15:0] first;
    logic [31:0] size;
    logic [31:0] limit;
    logic [31:0] slack;
    logic [31:0] blocks;
    int          steps;
    case ($urandom_range(0, 19))
      0: first = CHAIN_END;
      1: first = 16'($urandom_range(0, 1));
      2, 3: first = 16'($urandom_range(TABLE_ENTRIES, 16'hFFFE));
      default: first = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endcase
    case ($urandom_range(0, 9))
      0: size = $urandom();
      1, 2: size = 32'($urandom_range(0, 64)) * 32'(SECTOR_BYTES);
      3: size = 32'($urandom_range(0, 32 * SECTOR_BYTES));
      default: size = 32'($urandom_range(0, 8 * SECTOR_BYTES));
    endcase
    slack = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 4096));
    case ($urandom_range(0, 9))
      0: limit = $urandom();
      1: limit = (size == 0) ? 32'd0 : size - 32'd1;
      default: limit = (size > 32'hFFFF_FFFF - slack) ? '1 : size + slack;
    endcase
    start_file(first, size, limit);
    blocks = size / 32'(SECTOR_BYTES);
    steps = $urandom_range(1, (blocks > 20) ? 24 : int'(blocks) + 3);
    repeat (steps) begin
      case ($urandom_range(0, 24))
        0, 1: random_load();
        2: put_word(scrambled(ACT_NONE));
        default: ;
      endcase
      next_sector();
    end
  endtask

  task automatic directed_walks();
    in_word_t w;
    load_entry(16'd2, 16'd3);
    load_entry(16'd3, 16'd4);
    load_entry(16'd4, CHAIN_END);
    load_entry(16'd5, 16'd5);
    load_entry(16'd6, 16'd0);
    load_entry(16'(TABLE_ENTRIES - 1), 16'hFFFF);
    load_entry(16'd0, 16'(TABLE_ENTRIES - 1));
    load_entry(16'hFFFF, 16'h1234);
    w = '1;
    w.action = ACT_NONE;
    put_word(w);
    next_sector();
    start_file(CHAIN_END, 32'd0, 32'd0);
    next_sector();
    start_file(16'd2, 32'd1, 32'd0);
    next_sector();
    start_file(16'd0, 32'(SECTOR_BYTES), 32'(SECTOR_BYTES));
    next_sector();
    // walk to the chain end with the size out of reach
    start_file(16'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (5) next_sector();
    start_file(16'd2, 32'd1, 32'd1);
    next_sector();
  endtask

  initial begin : stimulus
    cfg_t geometry [PHASES];
    int   goal;
    geometry[0] = {16'd1, 8'd2, 16'd32, 16'd512, 8'd4};
    geometry[1] = {16'd0, 8'd1, 16'd1, 16'd0, 8'd1};
    geometry[2] = {16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd128};
    geometry[3] = {16'($urandom()), 8'($urandom_range(1, 255)),
                   16'($urandom_range(1, 65535)), 16'($urandom()), 8'd0};
    geometry[4] = {16'($urandom()), 8'($urandom_range(1, 255)),
                   16'($urandom_range(1, 65535)), 16'($urandom()),
                   8'($urandom_range(1, 8))};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    directed_walks();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        set_geometry(geometry[phase]);
      end
      goal = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) begin
        case ($urandom_range(0, 19))
          0, 1, 2: random_load();
          3: put_word(scrambled(ACT_NONE));
          4: next_sector();
          default: random_transfer();
        endcase
      end
    end
    drain();
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
